// ----- rtl/aas_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aas_pkg - alarm annunciator sequencer package
// Shared codes, widths, reset values and the cadence phase type.
// ----------------------------------------------------------------------------
package aas_pkg;

    // Field widths
    localparam int CMD_W    = 2;
    localparam int LEVEL_W  = 2;
    localparam int SNOOZE_W = 32;
    localparam int BEEP_W   = 16;
    localparam int QUIET_W  = 20;
    localparam int DUTY_W   = 12;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    // Stream payload widths, padded to whole bytes
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 16;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RAISE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_SNOOZE = 2'd3;

    // Alert levels
    localparam logic [LEVEL_W-1:0] LVL_NONE = 2'd0;
    localparam logic [LEVEL_W-1:0] LVL_WARN = 2'd1;
    localparam logic [LEVEL_W-1:0] LVL_CRIT = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_ARG   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_STATE = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BEEP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUIET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY  = 2'd2;

    // Register reset values
    localparam logic [BEEP_W-1:0]  BEEP_RST  = 16'd500;
    localparam logic [QUIET_W-1:0] QUIET_RST = 20'd20000;
    localparam logic [DUTY_W-1:0]  DUTY_RST  = 12'd1024;

    // Cadence phase
    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_BEEP   = 4'b0010,
        PH_QUIET  = 4'b0100,
        PH_SNOOZE = 4'b1000
    } phase_t;

endpackage

// ----- rtl/alarm_annunciator_sequencer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alarm_annunciator_sequencer - alarm lamp and buzzer cadence controller
// Runs ticks and alert commands into lamp levels and a buzzer PWM duty.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one command per item: tuser is the command
//   (tick, raise, clear, snooze), tdata holds the alert level and snooze
//   length. Master stream returns one result per item with both lamp
//   levels, the buzzer duty and a status code.
//   The cfg channel writes beep length, quiet length and buzzer duty by
//   index; it is always ready and should only be used while idle.
//   An accepted item waits in the input register, then passes through the
//   state update into the result register. One item per cycle is sustained
//   while the receiver takes results; the combinational state update (32-bit
//   countdown compare and decrement) sets that rate.
//   When the receiver stalls the result holds, the input register still
//   takes an item if it is empty, then s_tready drops until the result is taken.
//   Reset clears the level, cadence, snooze state and both valid flags and
//   loads the register defaults (500, 20000, 1024).
// ----------------------------------------------------------------------------
module alarm_annunciator_sequencer
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    // tuser: command[1:0]
    // tdata: alert_level[1:0], snooze_ms[33:2], zero pad[39:34]
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [aas_pkg::CMD_W-1:0]             s_tuser,
    input  logic [aas_pkg::IN_DATA_W-1:0]         s_tdata,
    // tdata: warning_lamp[0], critical_lamp[1], buzzer_duty[13:2],
    //        status[15:14]
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [aas_pkg::OUT_DATA_W-1:0]        m_tdata,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [aas_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [aas_pkg::CFG_DATA_W-1:0]        cfg_data
);

    // Configuration
    logic [aas_pkg::BEEP_W-1:0]   beep_time_reg;
    logic [aas_pkg::QUIET_W-1:0]  quiet_time_reg;
    logic [aas_pkg::DUTY_W-1:0]   duty_on_reg;

    // Input register
    logic                          in_vld_reg;
    logic [aas_pkg::CMD_W-1:0]     in_cmd_reg;
    logic [aas_pkg::LEVEL_W-1:0]   in_level_reg;
    logic [aas_pkg::SNOOZE_W-1:0]  in_snooze_reg;

    // Sequencer state
    logic [aas_pkg::LEVEL_W-1:0]   level_reg, level_next;
    aas_pkg::phase_t               phase_reg, phase_next;
    logic [aas_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic                          armed_reg, armed_next;
    logic [aas_pkg::SNOOZE_W-1:0]  snz_len_reg, snz_len_next;

    // Result register
    logic                          out_vld_reg;
    logic [aas_pkg::OUT_DATA_W-1:0] out_data_reg, out_data_next;

    logic                          advance;
    logic                          proc;
    logic                          in_take;
    logic [aas_pkg::STATUS_W-1:0]  status;
    logic [aas_pkg::DUTY_W-1:0]    duty;
    logic [aas_pkg::CNT_W-1:0]     beep_load;
    logic [aas_pkg::CNT_W-1:0]     quiet_load;

    assign advance   = !out_vld_reg || m_tready;
    assign proc      = in_vld_reg && advance;
    assign s_tready  = !in_vld_reg || advance;
    assign in_take   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_vld_reg;
    assign m_tdata   = out_data_reg;

    // A zero length register still gives a one-tick phase
    assign beep_load  = (beep_time_reg == '0) ? aas_pkg::CNT_W'(1)
                                              : aas_pkg::CNT_W'(beep_time_reg);
    assign quiet_load = (quiet_time_reg == '0) ? aas_pkg::CNT_W'(1)
                                               : aas_pkg::CNT_W'(quiet_time_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beep_time_reg  <= aas_pkg::BEEP_RST;
            quiet_time_reg <= aas_pkg::QUIET_RST;
            duty_on_reg    <= aas_pkg::DUTY_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                aas_pkg::REG_BEEP:  beep_time_reg  <= cfg_data[aas_pkg::BEEP_W-1:0];
                aas_pkg::REG_QUIET: quiet_time_reg <= cfg_data[aas_pkg::QUIET_W-1:0];
                aas_pkg::REG_DUTY:  duty_on_reg    <= cfg_data[aas_pkg::DUTY_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_cmd_reg    <= s_tuser;
            in_level_reg  <= s_tdata[aas_pkg::LEVEL_W-1:0];
            in_snooze_reg <= s_tdata[aas_pkg::LEVEL_W +: aas_pkg::SNOOZE_W];
        end
    end

    always_comb
    begin
        level_next   = level_reg;
        phase_next   = phase_reg;
        cnt_next     = cnt_reg;
        armed_next   = armed_reg;
        snz_len_next = snz_len_reg;
        status       = aas_pkg::ST_OK;

        case (in_cmd_reg)
            aas_pkg::CMD_TICK:
            begin
                if (level_reg == aas_pkg::LVL_CRIT && phase_reg != aas_pkg::PH_IDLE)
                begin
                    if (cnt_reg > aas_pkg::CNT_W'(1))
                    begin
                        cnt_next = cnt_reg - aas_pkg::CNT_W'(1);
                    end
                    else
                    begin
                        case (phase_reg)
                            aas_pkg::PH_BEEP:
                            begin
                                phase_next = aas_pkg::PH_QUIET;
                                cnt_next   = quiet_load;
                            end
                            aas_pkg::PH_QUIET:
                            begin
                                if (armed_reg && snz_len_reg != '0)
                                begin
                                    phase_next = aas_pkg::PH_SNOOZE;
                                    cnt_next   = snz_len_reg;
                                end
                                else
                                begin
                                    phase_next = aas_pkg::PH_BEEP;
                                    cnt_next   = beep_load;
                                end
                            end
                            aas_pkg::PH_SNOOZE:
                            begin
                                // one-shot wait: drop the stored length
                                snz_len_next = '0;
                                phase_next   = aas_pkg::PH_BEEP;
                                cnt_next     = beep_load;
                            end
                            default: ;
                        endcase
                    end
                end
            end
            aas_pkg::CMD_RAISE:
            begin
                if (in_level_reg inside {aas_pkg::LVL_WARN, aas_pkg::LVL_CRIT})
                begin
                    if (phase_reg == aas_pkg::PH_SNOOZE)
                    begin
                        snz_len_next = '0;
                    end
                    level_next = in_level_reg;
                    if (in_level_reg == aas_pkg::LVL_CRIT)
                    begin
                        phase_next = aas_pkg::PH_BEEP;
                        cnt_next   = beep_load;
                    end
                    else
                    begin
                        phase_next = aas_pkg::PH_IDLE;
                        cnt_next   = '0;
                    end
                end
                else
                begin
                    status = aas_pkg::ST_BAD_ARG;
                end
            end
            aas_pkg::CMD_CLEAR:
            begin
                if (phase_reg == aas_pkg::PH_SNOOZE)
                begin
                    snz_len_next = '0;
                end
                phase_next = aas_pkg::PH_IDLE;
                cnt_next   = '0;
                level_next = aas_pkg::LVL_NONE;
                armed_next = 1'b0;
            end
            aas_pkg::CMD_SNOOZE:
            begin
                if (level_reg != aas_pkg::LVL_CRIT)
                begin
                    status = aas_pkg::ST_BAD_STATE;
                end
                else
                begin
                    armed_next   = 1'b1;
                    snz_len_next = in_snooze_reg;
                end
            end
            default: ;
        endcase

        duty = (level_next == aas_pkg::LVL_CRIT && phase_next == aas_pkg::PH_BEEP)
               ? duty_on_reg : '0;
        out_data_next = {status, duty,
                         level_next == aas_pkg::LVL_CRIT,
                         level_next == aas_pkg::LVL_WARN};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg   <= aas_pkg::LVL_NONE;
            phase_reg   <= aas_pkg::PH_IDLE;
            cnt_reg     <= '0;
            armed_reg   <= 1'b0;
            snz_len_reg <= '0;
        end
        else if (proc)
        begin
            level_reg   <= level_next;
            phase_reg   <= phase_next;
            cnt_reg     <= cnt_next;
            armed_reg   <= armed_next;
            snz_len_reg <= snz_len_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

// ----- rtl/aas_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aas_checker - port-level checks for the alarm annunciator sequencer
// Watches the result stream for handshake and result consistency.
// ----------------------------------------------------------------------------
module aas_checker
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [aas_pkg::OUT_DATA_W-1:0] m_tdata
);

    // Hold a stalled result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed or dropped while stalled");

    // Never both lamps at once
    a_lamps: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("warning and critical lamps both lit");

    // Buzzer only sounds at critical level
    a_buzz: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[13:2] != '0) |-> m_tdata[1])
        else $error("buzzer on without critical lamp");

    // Status code in range
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[15:14] == aas_pkg::ST_OK ||
                      m_tdata[15:14] == aas_pkg::ST_BAD_ARG ||
                      m_tdata[15:14] == aas_pkg::ST_BAD_STATE))
        else $error("status code out of range");

    // No valid result follows a clock edge that sees reset asserted
    a_reset: assert property (@(posedge clk)
        !rst_n |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind alarm_annunciator_sequencer aas_checker u_aas_checker (.*);

// ----- tb/sv/alarm_annunciator_sequencer_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alarm_annunciator_sequencer_checker - result predictor and scoreboard
// Watches the command, result and register channels of the annunciator.
// For every command item it works out the lamps, buzzer duty and status
// that the block must return, and compares each returned result with the
// oldest prediction.
// ----------------------------------------------------------------------------
module alarm_annunciator_sequencer_checker
    import aas_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    input  logic                    s_tready,
    input  logic [CMD_W-1:0]        s_tuser,
    input  logic [IN_DATA_W-1:0]    s_tdata,
    input  logic                    m_tvalid,
    input  logic                    m_tready,
    input  logic [OUT_DATA_W-1:0]   m_tdata,
    input  logic                    cfg_valid,
    input  logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    output int                      mismatches,
    output int                      pending,
    output int                      results_checked,
    output int                      snooze_waits
);

    typedef struct {
        logic                warn;
        logic                crit;
        logic [DUTY_W-1:0]   duty;
        logic [STATUS_W-1:0] status;
    } lamp_state_t;

    // Register copies
    logic [BEEP_W-1:0]   beep_len;
    logic [QUIET_W-1:0]  quiet_len;
    logic [DUTY_W-1:0]   duty_on;

    // Annunciator state
    logic [LEVEL_W-1:0]  alert;
    phase_t              ph;
    logic [CNT_W-1:0]    countdown;
    logic                armed;
    logic [SNOOZE_W-1:0] snz_len;

    lamp_state_t         lamp_expect_q[$];
    lamp_state_t         want;
    int                  fail_count;
    int                  checked_count;
    int                  wait_count;

    assign mismatches = fail_count;

    task automatic report_mismatch(input string what, input longint got, input longint exp_val);
        $display("%0t: result %0d, %s: got %0h, expected %0h",
                 $realtime, checked_count, what, got, exp_val);
        fail_count++;
    endtask

    function automatic void start_beep();
        ph        = PH_BEEP;
        countdown = (beep_len == '0) ? CNT_W'(1) : CNT_W'(beep_len);
    endfunction

    // Abandoning a snooze wait loses its stored length
    function automatic void halt_cadence();
        if (ph == PH_SNOOZE)
            snz_len = '0;
        ph        = PH_IDLE;
        countdown = '0;
    endfunction

    function automatic void count_tick();
        if (alert != LVL_CRIT || ph == PH_IDLE)
            return;
        if (countdown > 1)
        begin
            countdown--;
            return;
        end
        case (ph)
            PH_BEEP:
            begin
                ph        = PH_QUIET;
                countdown = (quiet_len == '0) ? CNT_W'(1) : CNT_W'(quiet_len);
            end
            PH_QUIET:
            begin
                if (armed && snz_len != '0)
                begin
                    ph        = PH_SNOOZE;
                    countdown = snz_len;
                    wait_count++;
                end
                else
                    start_beep();
            end
            default:
            begin
                snz_len = '0;
                start_beep();
            end
        endcase
    endfunction

    function automatic lamp_state_t annunciate(input logic [CMD_W-1:0] cmd,
                                               input logic [LEVEL_W-1:0] req,
                                               input logic [SNOOZE_W-1:0] sms);
        lamp_state_t r;
        r.status = ST_OK;
        case (cmd)
            CMD_TICK:
                count_tick();
            CMD_RAISE:
            begin
                if (req == LVL_WARN || req == LVL_CRIT)
                begin
                    halt_cadence();
                    alert = req;
                    if (req == LVL_CRIT)
                        start_beep();
                end
                else
                    r.status = ST_BAD_ARG;
            end
            CMD_CLEAR:
            begin
                halt_cadence();
                alert = LVL_NONE;
                armed = 1'b0;
            end
            default:
            begin
                if (alert != LVL_CRIT)
                    r.status = ST_BAD_STATE;
                else
                begin
                    armed   = 1'b1;
                    snz_len = sms;
                end
            end
        endcase
        r.warn = (alert == LVL_WARN);
        r.crit = (alert == LVL_CRIT);
        r.duty = (alert == LVL_CRIT && ph == PH_BEEP) ? duty_on : '0;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beep_len      = BEEP_RST;
            quiet_len     = QUIET_RST;
            duty_on       = DUTY_RST;
            alert         = LVL_NONE;
            ph            = PH_IDLE;
            countdown     = '0;
            armed         = 1'b0;
            snz_len       = '0;
            fail_count    = 0;
            checked_count = 0;
            wait_count    = 0;
            lamp_expect_q.delete();
            pending         <= 0;
            results_checked <= 0;
            snooze_waits    <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_BEEP:  beep_len  = cfg_data[BEEP_W-1:0];
                    REG_QUIET: quiet_len = cfg_data[QUIET_W-1:0];
                    REG_DUTY:  duty_on   = cfg_data[DUTY_W-1:0];
                    default:   ;
                endcase
            end
            if (s_tvalid && s_tready)
                lamp_expect_q.push_back(annunciate(s_tuser, s_tdata[LEVEL_W-1:0],
                                                   s_tdata[LEVEL_W +: SNOOZE_W]));
            if (m_tvalid && m_tready)
            begin
                if (lamp_expect_q.size() == 0)
                    report_mismatch("result with nothing outstanding", m_tdata, 0);
                else
                begin
                    want = lamp_expect_q.pop_front();
                    if (m_tdata[0] !== want.warn)
                        report_mismatch("warning_lamp", m_tdata[0], want.warn);
                    if (m_tdata[1] !== want.crit)
                        report_mismatch("critical_lamp", m_tdata[1], want.crit);
                    if (m_tdata[2 +: DUTY_W] !== want.duty)
                        report_mismatch("buzzer_duty", m_tdata[2 +: DUTY_W], want.duty);
                    if (m_tdata[2 + DUTY_W +: STATUS_W] !== want.status)
                        report_mismatch("status", m_tdata[2 + DUTY_W +: STATUS_W],
                                        want.status);
                end
                checked_count++;
            end
            pending         <= lamp_expect_q.size();
            results_checked <= checked_count;
            snooze_waits    <= wait_count;
        end
    end

endmodule

// ----- tb/sv/alarm_annunciator_sequencer_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alarm_annunciator_sequencer_test - annunciator testbench top
// Drives directed commands and then random command streams through the
// block under six register settings and three idling mixes, while the
// checker predicts and compares every result.
// ----------------------------------------------------------------------------
module alarm_annunciator_sequencer_test;
    import aas_pkg::*;

    localparam logic [LEVEL_W-1:0] LVL_UNDEF = 2'd3;
    localparam int SEGMENTS      = 6;
    localparam int SEGMENT_ITEMS = 150;
    localparam int CYCLE_LIMIT   = 400000;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [CMD_W-1:0]       s_tuser = '0;      // command
    logic [IN_DATA_W-1:0]   s_tdata = '0;      // alert_level, snooze_ms, zero pad
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;           // warning, critical, duty, status
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    int mismatches;
    int pending;
    int results_checked;
    int snooze_waits;
    int items_sent = 0;
    int cycles = 0;
    int send_idle_pct = 24;
    int recv_idle_pct = 64;

    alarm_annunciator_sequencer u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    alarm_annunciator_sequencer_checker u_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tuser         (s_tuser),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .pending         (pending),
        .results_checked (results_checked),
        .snooze_waits    (snooze_waits)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("FAIL alarm_annunciator_sequencer");
            $finish;
        end
    end

    // Hold valid across back-to-back items; drop it only for a gap
    task automatic send_command(input logic [CMD_W-1:0] cmd,
                                input logic [LEVEL_W-1:0] lvl,
                                input logic [SNOOZE_W-1:0] sms);
        int gap;
        gap = 0;
        if ($urandom_range(0, 99) < send_idle_pct)
            gap = $urandom_range(1, 4);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {{(IN_DATA_W - LEVEL_W - SNOOZE_W){1'b0}}, sms, lvl};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
    endtask

    // Wait for every outstanding result, then let the pipeline drain
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_cadence(input logic [CFG_DATA_W-1:0] beep,
                                input logic [CFG_DATA_W-1:0] quiet,
                                input logic [CFG_DATA_W-1:0] duty);
        logic [CFG_DATA_W-1:0] vals [3];
        logic [CFG_IDX_W-1:0]  idxs [3];
        vals = '{beep, quiet, duty};
        idxs = '{REG_BEEP, REG_QUIET, REG_DUTY};
        for (int i = 0; i < 3; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idxs[i];
            cfg_data  <= vals[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random_command();
        logic [CMD_W-1:0]    cmd;
        logic [LEVEL_W-1:0]  lvl;
        logic [SNOOZE_W-1:0] sms;
        int                  r;
        lvl = LEVEL_W'($urandom_range(0, 3));
        sms = $urandom();
        r   = $urandom_range(0, 99);
        if (r < 55)
            cmd = CMD_TICK;
        else if (r < 72)
        begin
            cmd = CMD_RAISE;
            r   = $urandom_range(0, 99);
            if (r < 10)
                lvl = LVL_NONE;
            else if (r < 15)
                lvl = LVL_UNDEF;
            else if (r < 40)
                lvl = LVL_WARN;
            else
                lvl = LVL_CRIT;
        end
        else if (r < 78)
            cmd = CMD_CLEAR;
        else
        begin
            cmd = CMD_SNOOZE;
            r   = $urandom_range(0, 99);
            if (r < 10)
                sms = '0;
            else if (r < 85)
                sms = SNOOZE_W'($urandom_range(1, 6));
            else if (r >= 95)
                sms = '1;
        end
        send_command(cmd, lvl, sms);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset register values: illegal arguments, warning, critical restart
        send_command(CMD_TICK,   LVL_UNDEF, '1);
        send_command(CMD_RAISE,  LVL_NONE,  '0);
        send_command(CMD_RAISE,  LVL_UNDEF, '0);
        send_command(CMD_SNOOZE, LVL_NONE,  '1);
        send_command(CMD_RAISE,  LVL_WARN,  '0);
        send_command(CMD_SNOOZE, LVL_CRIT,  32'd7);
        send_command(CMD_RAISE,  LVL_CRIT,  '0);
        send_command(CMD_TICK,   LVL_NONE,  '0);
        send_command(CMD_RAISE,  LVL_CRIT,  '0);
        send_command(CMD_CLEAR,  LVL_WARN,  '1);
        drain_results();

        // Short beep, zero quiet (one tick), full duty: walk a snooze wait
        load_cadence(20'd2, 20'd0, 20'hFFF);
        send_command(CMD_RAISE,  LVL_CRIT,  '0);
        send_command(CMD_SNOOZE, LVL_NONE,  32'd3);
        repeat (3) send_command(CMD_TICK, LVL_NONE, '0);
        send_command(CMD_SNOOZE, LVL_NONE,  32'hAAAA5555);
        repeat (5) send_command(CMD_TICK, LVL_NONE, '0);
        send_command(CMD_TICK,   LVL_NONE,  '0);
        send_command(CMD_SNOOZE, LVL_NONE,  '0);
        send_command(CMD_CLEAR,  LVL_NONE,  '0);
        send_command(CMD_TICK,   LVL_CRIT,  '1);

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            drain_results();
            case (seg / 2)
                0:       begin send_idle_pct = 24; recv_idle_pct = 64; end
                1:       begin send_idle_pct = 64; recv_idle_pct = 24; end
                default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            endcase
            case (seg)
                0: load_cadence(20'd1, 20'd1, 20'd0);
                2: load_cadence(20'hFFFF, 20'hFFFFF, 20'hFFF);
                4: load_cadence(20'd0, 20'd0, CFG_DATA_W'($urandom_range(0, 4095)));
                5: load_cadence(CFG_DATA_W'($urandom_range(1, 6) | ($urandom_range(0, 15) << 16)),
                                CFG_DATA_W'($urandom_range(1, 6)),
                                CFG_DATA_W'($urandom_range(0, 1048575)));
                default: load_cadence(CFG_DATA_W'($urandom_range(1, 6)),
                                      CFG_DATA_W'($urandom_range(1, 6)),
                                      CFG_DATA_W'($urandom_range(0, 4095)));
            endcase
            for (int i = 0; i < SEGMENT_ITEMS; i++)
                send_random_command();
        end

        drain_results();
        repeat (8) @(posedge clk);
        $display("%0d commands sent, %0d results checked, %0d snooze waits entered",
                 items_sent, results_checked, snooze_waits);
        $display("register settings: reset, short and zero phases, both extremes");
        if (mismatches == 0 && pending == 0)
            $display("PASS alarm_annunciator_sequencer");
        else
            $display("FAIL alarm_annunciator_sequencer");
        $finish;
    end

endmodule
